/* src/psl_pkg.sv */
package psl_pkg;

    // Item kinds on the input channel
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Q1.16 one, and the number of bit steps in the multiply and divide loops
    localparam logic [16:0] ONE_Q16   = 17'h10000;
    localparam int          STEPS     = 16;
    localparam int          CNT_W     = 4;
    localparam logic [3:0]  LAST_STEP = 4'(STEPS - 1);

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_SINGLE   = 3'd2,
        ST_BEFORE   = 3'd3,
        ST_ZERO_SEG = 3'd4
    } t_status;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LAST,
        S_MUL,
        S_FIRST,
        S_SEARCH,
        S_CMP,
        S_RD1,
        S_RD2,
        S_CHK_LO,
        S_CHK_HI,
        S_DIVISOR,
        S_DIV,
        S_DONE
    } t_state;

    // One stored vertex: position and heading
    typedef struct packed {
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
        logic signed [15:0] head_y;
        logic signed [15:0] head_x;
    } t_vertex;

    typedef struct packed {
        logic               kind;
        logic [7:0]         entry_index;
        logic [31:0]        cum_length;
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic signed [15:0] heading_x;
        logic signed [15:0] heading_y;
        logic [16:0]        fraction;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic [7:0]         segment_index;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [15:0] start_head_x;
        logic signed [15:0] start_head_y;
        logic signed [15:0] end_head_x;
        logic signed [15:0] end_head_y;
        logic [16:0]        alpha;
    } t_out_item;

endpackage

/* src/psl_alu.sv */
module psl_alu
    import psl_pkg::*;
#(
    parameter int W = 33
) (
    input  t_alu_op      i_op,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic [W:0]   o_res
);

    // Add or subtract; the top bit is the carry out or the borrow
    always_comb begin
        unique case (i_op)
            ALU_ADD: o_res = {1'b0, i_a} + {1'b0, i_b};
            ALU_SUB: o_res = {1'b0, i_a} - {1'b0, i_b};
            default: o_res = '0;
        endcase
    end

endmodule

/* src/psl_tables.sv */
module psl_tables
    import psl_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int LW    = 32,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [LW-1:0] i_wr_len,
    input  t_vertex       i_wr_vtx,
    input  logic [AW-1:0] i_rd_addr,
    output logic [LW-1:0] o_rd_len,
    output t_vertex       o_rd_vtx
);

    logic [LW-1:0] r_len_mem [DEPTH];
    t_vertex       r_vtx_mem [DEPTH];

    // Length table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_len_mem[i_wr_addr] <= i_wr_len;
        end
        o_rd_len <= r_len_mem[i_rd_addr];
    end

    // Position and heading table, same addressing
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_vtx_mem[i_wr_addr] <= i_wr_vtx;
        end
        o_rd_vtx <= r_vtx_mem[i_rd_addr];
    end

endmodule

/* src/polyline_segment_locate.sv */
// Channel   Direction  Handshake               Payload
// in        input      i_in_valid / o_in_stall t_in_item  (load vertex or query)
// out       output     o_out_valid / i_out_stall t_out_item (one per query)
// cfg       input      i_cfg_valid / o_cfg_ready vertex_count, 9 bits
//
// A load is written to the tables on its transfer. A query runs 16 shift-add
// steps for the target length (skipped for a full fraction), a binary search
// whose probes each pass S_SEARCH and S_CMP on the table read port, and, for s
// inside a segment, 16 restoring divide steps for alpha, all on the one shared
// add/subtract unit. Reset is synchronous, active low; it clears the sequencer,
// the output valid and vertex_count. Table contents are undefined until loaded.
// A finished result waits in the output register while i_out_stall is high; the
// block takes new loads meanwhile, and a following query waits at its end.
module polyline_segment_locate
    import psl_pkg::*;
#(
    parameter int MAX_VERTICES = 256,
    parameter int LENGTH_BITS  = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_in_item   i_in_data,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output t_out_item  o_out_data,
    input  logic       i_out_stall,
    input  logic       i_cfg_valid,
    input  logic [8:0] i_cfg_data,
    output logic       o_cfg_ready
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int LB = LENGTH_BITS;
    localparam int OW = LENGTH_BITS + 1;

    t_state           r_state, n_state;
    logic             r_o_valid, n_o_valid;
    logic [8:0]       r_vertex_count;
    t_out_item        r_out, n_out;
    logic [15:0]      r_frac, n_frac;
    logic             r_frac_one, n_frac_one;
    logic [LB-1:0]    r_last, n_last;
    logic [LB-1:0]    r_s, n_s;
    logic [LB-1:0]    r_s0, n_s0;
    logic [LB-1:0]    r_s1, n_s1;
    logic [LB-1:0]    r_rem, n_rem;
    logic [LB-1:0]    r_d, n_d;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [NW-1:0]    r_lo, n_lo;
    logic [NW-1:0]    r_hi, n_hi;
    logic [AW-1:0]    r_i, n_i;
    logic [AW-1:0]    r_ip, n_ip;
    t_vertex          r_start_vtx, n_start_vtx;
    t_vertex          r_end_vtx, n_end_vtx;
    logic [16:0]      r_alpha, n_alpha;
    t_status          r_status, n_status;

    logic             w_in_xfer;
    logic             w_wr_en;
    t_vertex          w_wr_vtx;
    logic [AW-1:0]    w_rd_addr;
    logic [LB-1:0]    w_rd_len;
    t_vertex          w_rd_vtx;
    logic [NW-1:0]    w_n;
    logic [NW:0]      w_mid_sum;
    logic [NW-1:0]    w_mid;
    logic [NW-1:0]    w_i_clamp;
    t_alu_op          w_alu_op;
    logic [OW-1:0]    w_alu_a;
    logic [OW-1:0]    w_alu_b;
    logic [OW:0]      w_alu_res;
    logic             w_borrow;
    logic [LB-1:0]    w_diff;
    logic             w_out_free;
    logic             w_err;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_free = !r_o_valid || !i_out_stall;

    // Vertices in use, clamped to the table depth
    assign w_n = (32'(r_vertex_count) > 32'(MAX_VERTICES)) ?
                 NW'(MAX_VERTICES) : NW'(r_vertex_count);

    // Search midpoint and final index clamped to the last vertex
    assign w_mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid     = w_mid_sum[NW:1];
    assign w_i_clamp = (r_lo >= w_n) ? (w_n - NW'(1)) : r_lo;

    // Table write on a load transfer within the table depth
    assign w_wr_en = w_in_xfer && (i_in_data.kind == KIND_LOAD) &&
                     (32'(i_in_data.entry_index) < 32'(MAX_VERTICES));
    always_comb begin
        w_wr_vtx.pos_x  = i_in_data.vertex_x;
        w_wr_vtx.pos_y  = i_in_data.vertex_y;
        w_wr_vtx.head_x = i_in_data.heading_x;
        w_wr_vtx.head_y = i_in_data.heading_y;
    end

    psl_tables #(
        .DEPTH (MAX_VERTICES),
        .LW    (LB),
        .AW    (AW)
    ) u_tables (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (AW'(i_in_data.entry_index)),
        .i_wr_len  (LB'(i_in_data.cum_length)),
        .i_wr_vtx  (w_wr_vtx),
        .i_rd_addr (w_rd_addr),
        .o_rd_len  (w_rd_len),
        .o_rd_vtx  (w_rd_vtx)
    );

    psl_alu #(
        .W (OW)
    ) u_alu (
        .i_op  (w_alu_op),
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .o_res (w_alu_res)
    );

    assign w_borrow = w_alu_res[OW];
    assign w_diff   = w_alu_res[LB-1:0];
    assign w_err    = (r_status == ST_EMPTY) || (r_status == ST_SINGLE) ||
                      (r_status == ST_BEFORE);

    // Sequencer: next state, shared unit operands, table read address
    always_comb begin
        n_state     = r_state;
        n_o_valid   = r_o_valid && i_out_stall;
        n_out       = r_out;
        n_frac      = r_frac;
        n_frac_one  = r_frac_one;
        n_last      = r_last;
        n_s         = r_s;
        n_s0        = r_s0;
        n_s1        = r_s1;
        n_rem       = r_rem;
        n_d         = r_d;
        n_cnt       = r_cnt;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_i         = r_i;
        n_ip        = r_ip;
        n_start_vtx = r_start_vtx;
        n_end_vtx   = r_end_vtx;
        n_alpha     = r_alpha;
        n_status    = r_status;
        w_rd_addr   = '0;
        w_alu_op    = ALU_SUB;
        w_alu_a     = {1'b0, r_s};
        w_alu_b     = {1'b0, r_s0};

        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer && i_in_data.kind == KIND_QUERY) begin
                    n_alpha    = '0;
                    n_status   = ST_OK;
                    n_frac     = i_in_data.fraction[15:0];
                    n_frac_one = (i_in_data.fraction >= ONE_Q16);
                    w_rd_addr  = AW'(w_n - NW'(1));
                    priority if (w_n == '0) begin
                        n_status = ST_EMPTY;
                        n_state  = S_DONE;
                    end else if (w_n == NW'(1)) begin
                        n_status = ST_SINGLE;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_LAST;
                    end
                end
            end
            S_LAST: begin
                // Last cumulative length; a full fraction takes it as is
                n_last = w_rd_len;
                n_cnt  = '0;
                if (r_frac_one) begin
                    n_s       = w_rd_len;
                    w_rd_addr = '0;
                    n_state   = S_FIRST;
                end else begin
                    n_s     = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                // Shift-add, fraction LSB first, floor kept at every step
                w_alu_op = ALU_ADD;
                w_alu_a  = {1'b0, r_s};
                w_alu_b  = r_frac[0] ? {1'b0, r_last} : '0;
                n_s      = w_alu_res[LB:1];
                n_frac   = {1'b0, r_frac[15:1]};
                n_cnt    = r_cnt + CNT_W'(1);
                if (r_cnt == LAST_STEP) begin
                    w_rd_addr = '0;
                    n_state   = S_FIRST;
                end
            end
            S_FIRST: begin
                w_alu_a = {1'b0, r_s};
                w_alu_b = {1'b0, w_rd_len};
                if (w_borrow) begin
                    n_status = ST_BEFORE;
                    n_state  = S_DONE;
                end else begin
                    n_lo    = '0;
                    n_hi    = w_n;
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                priority if (r_lo < r_hi) begin
                    w_rd_addr = AW'(w_mid);
                    n_state   = S_CMP;
                end else if (r_lo == '0) begin
                    n_status = ST_BEFORE;
                    n_state  = S_DONE;
                end else begin
                    n_i       = AW'(w_i_clamp);
                    n_ip      = AW'(w_i_clamp - NW'(1));
                    w_rd_addr = AW'(w_i_clamp - NW'(1));
                    n_state   = S_RD1;
                end
            end
            S_CMP: begin
                // Probe length <= s moves the low bound past the midpoint
                w_alu_a = {1'b0, r_s};
                w_alu_b = {1'b0, w_rd_len};
                if (!w_borrow) begin
                    n_lo = w_mid + NW'(1);
                end else begin
                    n_hi = w_mid;
                end
                n_state = S_SEARCH;
            end
            S_RD1: begin
                n_s0        = w_rd_len;
                n_start_vtx = w_rd_vtx;
                w_rd_addr   = r_i;
                n_state     = S_RD2;
            end
            S_RD2: begin
                n_s1      = w_rd_len;
                n_end_vtx = w_rd_vtx;
                w_alu_a   = {1'b0, r_s0};
                w_alu_b   = {1'b0, w_rd_len};
                if (!w_borrow) begin
                    n_status = ST_ZERO_SEG;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_CHK_LO;
                end
            end
            S_CHK_LO: begin
                // s below the segment start gives alpha zero
                w_alu_a = {1'b0, r_s};
                w_alu_b = {1'b0, r_s0};
                n_rem   = w_diff;
                if (w_borrow) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_CHK_HI;
                end
            end
            S_CHK_HI: begin
                // s at or past the segment end saturates alpha
                w_alu_a = {1'b0, r_s};
                w_alu_b = {1'b0, r_s1};
                if (!w_borrow) begin
                    n_alpha = ONE_Q16;
                    n_state = S_DONE;
                end else begin
                    n_state = S_DIVISOR;
                end
            end
            S_DIVISOR: begin
                w_alu_a = {1'b0, r_s1};
                w_alu_b = {1'b0, r_s0};
                n_d     = w_diff;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                // Restoring divide, one quotient bit per step
                w_alu_a = {r_rem, 1'b0};
                w_alu_b = {1'b0, r_d};
                if (!w_borrow) begin
                    n_rem = w_diff;
                end else begin
                    n_rem = {r_rem[LB-2:0], 1'b0};
                end
                n_alpha = {r_alpha[15:0], !w_borrow};
                n_cnt   = r_cnt + CNT_W'(1);
                if (r_cnt == LAST_STEP) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Hand the result to the output register once it is free
                if (w_out_free) begin
                    n_o_valid            = 1'b1;
                    n_out.status         = r_status;
                    n_out.segment_index  = w_err ? '0 : 8'(r_ip);
                    n_out.start_x        = w_err ? '0 : r_start_vtx.pos_x;
                    n_out.start_y        = w_err ? '0 : r_start_vtx.pos_y;
                    n_out.end_x          = w_err ? '0 : r_end_vtx.pos_x;
                    n_out.end_y          = w_err ? '0 : r_end_vtx.pos_y;
                    n_out.start_head_x   = w_err ? '0 : r_start_vtx.head_x;
                    n_out.start_head_y   = w_err ? '0 : r_start_vtx.head_y;
                    n_out.end_head_x     = w_err ? '0 : r_end_vtx.head_x;
                    n_out.end_head_y     = w_err ? '0 : r_end_vtx.head_y;
                    n_out.alpha          = (r_status == ST_OK) ? r_alpha : '0;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_o_valid      <= 1'b0;
            r_vertex_count <= '0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_vertex_count <= i_cfg_data;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_out       <= n_out;
        r_frac      <= n_frac;
        r_frac_one  <= n_frac_one;
        r_last      <= n_last;
        r_s         <= n_s;
        r_s0        <= n_s0;
        r_s1        <= n_s1;
        r_rem       <= n_rem;
        r_d         <= n_d;
        r_cnt       <= n_cnt;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_i         <= n_i;
        r_ip        <= n_ip;
        r_start_vtx <= n_start_vtx;
        r_end_vtx   <= n_end_vtx;
        r_alpha     <= n_alpha;
        r_status    <= n_status;
    end

endmodule

/* src/psl_checker.sv */
module psl_checker
    import psl_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input t_in_item   i_in_data,
    input logic       i_in_stall,
    input logic       i_out_valid,
    input t_out_item  i_out_data,
    input logic       i_out_stall
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed or dropped");

    // A query transfer occupies the block in the next cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_stall && i_in_data.kind == KIND_QUERY |=> i_in_stall)
        else $error("block ready right after a query transfer");

    // A load transfer leaves the block ready
    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_stall && i_in_data.kind == KIND_LOAD |=> !i_in_stall)
        else $error("load transfer left the block busy");

    // Error results carry no segment and no weight
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_data.status == ST_EMPTY ||
                        i_out_data.status == ST_SINGLE ||
                        i_out_data.status == ST_BEFORE) |->
        i_out_data.alpha == '0 && i_out_data.segment_index == '0 &&
        i_out_data.start_x == '0 && i_out_data.end_y == '0)
        else $error("error result carries segment data");

    // Alpha never exceeds one, and a zero-length segment gives none
    a_alpha_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (!i_out_data.alpha[16] || i_out_data.alpha[15:0] == '0) &&
        (i_out_data.status != ST_ZERO_SEG || i_out_data.alpha == '0))
        else $error("alpha out of range");

endmodule

bind polyline_segment_locate psl_checker u_psl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_data   (i_in_data),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);
